/* design/spq_pkg.sv */
// Shared types and constants for the stable priority queue.
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int PRIO_W      = 4;
    localparam int ID_W        = 16;
    localparam int REM_W       = 14;
    localparam int OUT_CNT_W   = 5;
    localparam int ENTRY_W     = PRIO_W + ID_W + REM_W;
    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 40;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_POP    = 1'b1
    } t_opcode;

    // priority in the lowest bits
    typedef struct packed {
        logic [REM_W-1:0]  remaining;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    typedef struct packed {
        logic insert_en;
        logic pop_en;
    } t_cell_ctrl;

endpackage

/* design/spq_cell.sv */
// One queue slot: compares against the incoming entry and shifts with its neighbors.
module spq_cell
    import spq_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  t_entry     i_new,
    input  logic       i_valid,      // slot lies below the fill count
    input  logic       i_left_keep,  // left neighbor stays put on insert
    input  t_entry     i_left_data,
    input  t_entry     i_right_data,
    output logic       o_keep,
    output t_entry     o_data
);

    t_entry r_data;
    t_entry n_data;

    // keep is a prefix of the row since entries are sorted high to low
    assign o_keep = i_valid && (r_data.prio >= i_new.prio);
    assign o_data = r_data;

    always_comb begin
        n_data = r_data;
        if (i_ctrl.insert_en) begin
            if (!o_keep) begin
                n_data = i_left_keep ? i_new : i_left_data;
            end
        end else if (i_ctrl.pop_en) begin
            n_data = i_right_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

/* design/stable_priority_queue.sv */
// Stable priority queue: sorted row of slots, one operation per transaction.
//
// Input channel (s): tuser carries the opcode (insert or pop), tdata the
// entry to insert (priority, id, remaining time). The entry fields are
// ignored on a pop.
// Output channel (m): one transaction per input transaction. tuser is the
// success flag, tdata the popped entry (zero unless a pop succeeded), the
// empty flag and the entry count after the operation.
// The result is registered and appears in the cycle after the input transaction.
// One operation per cycle unless the receiver stalls; every slot compares and
// shifts in parallel, whatever the fill level.
// Higher priorities leave first; equal priorities leave in arrival order.
// An insert into a full queue and a pop on an empty queue return success 0
// and leave the contents untouched.
// Reset clears the fill count and the output valid flag; slot contents need
// no clearing since only slots below the count are ever read.
// When the receiver stalls, the result is held in the output register and
// the input accepts once more only when that result is taken.
module stable_priority_queue
    import spq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,  // [3:0] priority, [19:4] id, [33:20] remaining
    input  logic                  i_s_tuser,  // [0] opcode
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,  // [3:0] priority, [19:4] id,
                                              // [33:20] remaining, [34] empty, [39:35] count
    output logic                  o_m_tuser   // [0] success
);

    t_entry     w_new;
    t_opcode    w_op;
    logic       w_fire;
    logic       w_full;
    logic       w_empty;
    t_cell_ctrl w_ctrl;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    logic             r_out_valid;
    logic             r_out_success;
    t_entry           r_out_entry;
    logic [CNT_W-1:0] r_out_count;

    logic   w_keep [QUEUE_DEPTH];
    t_entry w_data [QUEUE_DEPTH];

    assign w_new   = t_entry'(i_s_tdata[ENTRY_W-1:0]);
    assign w_op    = t_opcode'(i_s_tuser);
    assign w_fire  = i_s_tvalid && o_s_tready;
    assign w_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_empty = (r_count == '0);

    assign w_ctrl.insert_en = w_fire && (w_op == OP_INSERT) && !w_full;
    assign w_ctrl.pop_en    = w_fire && (w_op == OP_POP) && !w_empty;

    always_comb begin
        n_count = r_count;
        if (w_ctrl.insert_en) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctrl.pop_en) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic   w_left_keep;
        t_entry w_left_data;
        t_entry w_right_data;

        if (i == 0) begin : g_head
            assign w_left_keep = 1'b1;
            assign w_left_data = w_new;
        end else begin : g_body
            assign w_left_keep = w_keep[i-1];
            assign w_left_data = w_data[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_tail
            assign w_right_data = '0;
        end else begin : g_mid
            assign w_right_data = w_data[i+1];
        end

        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_new        (w_new),
            .i_valid      (CNT_W'(i) < r_count),
            .i_left_keep  (w_left_keep),
            .i_left_data  (w_left_data),
            .i_right_data (w_right_data),
            .o_keep       (w_keep[i]),
            .o_data       (w_data[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_success <= w_ctrl.insert_en || w_ctrl.pop_en;
            r_out_entry   <= w_ctrl.pop_en ? w_data[0] : '0;
            r_out_count   <= n_count;
        end
    end

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_success;
    assign o_m_tdata  = {OUT_CNT_W'(r_out_count), (r_out_count == '0), r_out_entry};

endmodule

/* design/spq_checker.sv */
// Port-level checks for the stable priority queue, bound to the top level.
module spq_checker
    import spq_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] o_m_tdata,
    input logic                  o_m_tuser
);

    // result held under back-pressure
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    // every input transaction yields a result on the next cycle
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> o_m_tvalid)
        else $error("result missing after input transaction");

    // a refused operation reports no entry
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> (o_m_tdata[ENTRY_W-1:0] == '0))
        else $error("refused operation carries entry data");

    // empty flag agrees with the count
    a_empty_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[ENTRY_W] ==
                        (o_m_tdata[ENTRY_W+OUT_CNT_W:ENTRY_W+1] == '0)))
        else $error("empty flag disagrees with count");

endmodule

bind stable_priority_queue spq_checker u_spq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

/* tb/tb_stable_priority_queue.sv */
// Self-checking testbench for the stable priority queue: directed and random stimulus with stalls.
module tb_stable_priority_queue;
    import spq_pkg::*;

    localparam int RANDOM_ITEMS = 1500;
    localparam int QUIET_TAIL   = 150;   // last items run with no idling
    localparam int HOLD_AT      = 400;   // results seen before the long receiver hold-off
    localparam int HOLD_CYCLES  = 200;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [ID_W-1:0]   pid;
        logic [REM_W-1:0]  run_left;
    } t_proc_entry;

    typedef struct {
        t_opcode     op;
        t_proc_entry ent;
    } t_sched_req;

    typedef struct {
        logic                 ok;
        t_proc_entry          head;
        logic                 empty;
        logic [OUT_CNT_W-1:0] count;
    } t_sched_resp;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;   // [3:0] priority, [19:4] id, [33:20] remaining
    logic                  i_s_tuser;   // [0] opcode
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;   // [3:0] priority, [19:4] id, [33:20] remaining,
                                        // [34] empty, [39:35] count
    logic                  o_m_tuser;   // [0] success

    stable_priority_queue u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // golden copy of the queue
    t_proc_entry sched_slots [QUEUE_DEPTH];
    int          sched_count;

    t_sched_req  pending_ops[$];
    t_sched_resp exp_results[$];
    int          total_ops;
    int          ops_taken;
    int          results_seen;
    int          err_count;
    bit          s_took;
    int          tx_gap;
    int          rx_stall;
    int          rx_hold;
    bit          hold_done;
    t_sched_req  drv_req;
    t_sched_req  mon_req;
    t_sched_resp mon_rsp;
    t_sched_resp exp_rsp;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic sched_queue_step(input t_sched_req req, output t_sched_resp rsp);
        int pos;
        int k;
        rsp.ok   = 1'b0;
        rsp.head = '0;
        if (req.op == OP_INSERT) begin
            if (sched_count < QUEUE_DEPTH) begin
                // ties go behind existing entries of the same priority
                pos = 0;
                while (pos < sched_count && sched_slots[pos].prio >= req.ent.prio)
                    pos++;
                for (k = sched_count; k > pos; k--)
                    sched_slots[k] = sched_slots[k-1];
                sched_slots[pos] = req.ent;
                sched_count++;
                rsp.ok = 1'b1;
            end
        end else if (sched_count > 0) begin
            rsp.head = sched_slots[0];
            for (k = 1; k < sched_count; k++)
                sched_slots[k-1] = sched_slots[k];
            sched_count--;
            rsp.ok = 1'b1;
        end
        rsp.empty = (sched_count == 0);
        rsp.count = sched_count[OUT_CNT_W-1:0];
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            err_count++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    task automatic queue_insert(input int prio, input int pid, input int run_left);
        t_sched_req r;
        r.op           = OP_INSERT;
        r.ent.prio     = prio[PRIO_W-1:0];
        r.ent.pid      = pid[ID_W-1:0];
        r.ent.run_left = run_left[REM_W-1:0];
        pending_ops.push_back(r);
    endtask

    task automatic queue_pop();
        t_sched_req r;
        r.op  = OP_POP;
        // payload is don't-care on a pop; keep it noisy
        r.ent = t_proc_entry'(ENTRY_W'({$urandom, $urandom}));
        pending_ops.push_back(r);
    endtask

    // sender: one item per accepted transaction, random gaps between items
    always @(negedge i_clk) begin
        if (s_took || !i_s_tvalid) begin
            s_took = 1'b0;
            if (tx_gap > 0) begin
                tx_gap--;
                i_s_tvalid <= 1'b0;
            end else if (i_rst_n && pending_ops.size() > 0) begin
                drv_req = pending_ops.pop_front();
                i_s_tuser  <= drv_req.op;
                i_s_tdata  <= IN_DATA_W'({drv_req.ent.run_left, drv_req.ent.pid,
                                          drv_req.ent.prio});
                i_s_tvalid <= 1'b1;
                if (pending_ops.size() > QUIET_TAIL && $urandom_range(0, 3) == 0)
                    tx_gap = $urandom_range(1, 7);
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: short random stalls plus one long hold-off to back up the input
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            i_m_tready <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_done = 1'b1;
            rx_hold   = HOLD_CYCLES - 1;
            i_m_tready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            i_m_tready <= 1'b0;
        end else if (pending_ops.size() > QUIET_TAIL && $urandom_range(0, 4) == 0) begin
            rx_stall = $urandom_range(0, 6);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // monitor: predict on input transactions, check output transactions
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                mon_req.op           = t_opcode'(i_s_tuser);
                mon_req.ent.prio     = i_s_tdata[PRIO_W-1:0];
                mon_req.ent.pid      = i_s_tdata[PRIO_W +: ID_W];
                mon_req.ent.run_left = i_s_tdata[PRIO_W+ID_W +: REM_W];
                sched_queue_step(mon_req, mon_rsp);
                exp_results.push_back(mon_rsp);
                ops_taken++;
                s_took = 1'b1;
            end
            if (o_m_tvalid && i_m_tready) begin
                results_seen++;
                if (exp_results.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected result: expected none, actual tdata %0h tuser %0b",
                             $time, o_m_tdata, o_m_tuser);
                end else begin
                    exp_rsp = exp_results.pop_front();
                    check_field("success", 32'(exp_rsp.ok), 32'(o_m_tuser));
                    check_field("popped_priority", 32'(exp_rsp.head.prio),
                                32'(o_m_tdata[PRIO_W-1:0]));
                    check_field("popped_id", 32'(exp_rsp.head.pid),
                                32'(o_m_tdata[PRIO_W +: ID_W]));
                    check_field("popped_remaining", 32'(exp_rsp.head.run_left),
                                32'(o_m_tdata[PRIO_W+ID_W +: REM_W]));
                    check_field("queue_empty", 32'(exp_rsp.empty), 32'(o_m_tdata[ENTRY_W]));
                    check_field("entry_count", 32'(exp_rsp.count),
                                32'(o_m_tdata[ENTRY_W+1 +: OUT_CNT_W]));
                end
            end
        end
    end

    initial begin
        int n;
        int burst_len;
        int mode;
        int ins_pct;
        bit narrow;
        int base_prio;
        int p;

        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = 1'b0;
        i_m_tready = 1'b0;
        sched_count  = 0;
        ops_taken    = 0;
        results_seen = 0;
        err_count    = 0;
        s_took       = 1'b0;
        tx_gap       = 0;
        rx_stall     = 0;
        rx_hold      = 0;
        hold_done    = 1'b0;

        // directed: empty pop, fill with extremes and ties, refused insert, partial drain
        queue_pop();
        queue_insert(0, 16'h0000, 14'h0000);
        queue_insert(15, 16'hFFFF, 14'h3FFF);
        queue_insert(7, 16'h0101, 14'h0011);
        queue_insert(7, 16'h0102, 14'h0022);
        queue_insert(7, 16'h0103, 14'h0033);
        queue_insert(15, 16'h0F02, 14'h1555);
        queue_insert(0, 16'h0002, 14'h2AAA);
        queue_insert(3, 16'h0301, 14'h0001);
        queue_insert(12, 16'h0C01, 14'h3FFE);
        queue_insert(7, 16'h0104, 14'h0044);
        queue_insert(1, 16'h0201, 14'h0100);
        queue_insert(15, 16'h0F03, 14'h0200);
        queue_insert(8, 16'h0801, 14'h0400);
        queue_insert(8, 16'h0802, 14'h0800);
        queue_insert(2, 16'hAAAA, 14'h1000);
        queue_insert(14, 16'h5555, 14'h2000);
        queue_insert(9, 16'hDEAD, 14'h3000);   // queue full here: refused
        repeat (6) queue_pop();

        // random: bursts biased toward filling, draining or mixing,
        // some with a narrow priority band so ties are common
        n = 0;
        while (n < RANDOM_ITEMS) begin
            burst_len = $urandom_range(10, 40);
            mode      = $urandom_range(0, 2);
            ins_pct   = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
            narrow    = $urandom_range(0, 1);
            base_prio = $urandom_range(0, 14);
            repeat (burst_len) begin
                if ($urandom_range(0, 99) < ins_pct) begin
                    p = narrow ? base_prio + $urandom_range(0, 1) : $urandom_range(0, 15);
                    queue_insert(p, $urandom, $urandom);
                end else begin
                    queue_pop();
                end
                n++;
            end
        end
        total_ops = pending_ops.size();

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        while (ops_taken < total_ops || exp_results.size() > 0)
            @(negedge i_clk);
        repeat (10) @(posedge i_clk);

        if (exp_results.size() > 0) begin
            err_count++;
            $display("%0t: %0d results still expected, actual none", $time, exp_results.size());
        end
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
